[design/connected_component_labeling_core_assert.svh]
// Assertion macros for the connected component labeling core.
`ifndef CONNECTED_COMPONENT_LABELING_CORE_ASSERT_SVH
`define CONNECTED_COMPONENT_LABELING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CCL_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CCL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCL_ASSERT_IMPL(name, ante, cons, msg)
`define CCL_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

[design/ccl_pkg.sv]
// Shared constants and types for the connected component labeling core.
package ccl_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = XW + YW;
	localparam int PIX_DEPTH  = 2 ** ADDR_W;
	localparam int SP_W       = ADDR_W + 1;
	localparam int LABEL_W    = 16;
	localparam int CFG_W      = 9;
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_POP,
		ST_POP_WAIT,
		ST_NB
	} ccl_state_t;
endpackage

[design/ccl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/connected_component_labeling_core.sv]
// Load: one pixel per cycle while in_stall is low; input stalls while labeling. Fetch:
// label_q takes the registered RAM read as out_valid rises; a fetch stalls while one is
// pending or a result is held. Labeling after the last pixel scans each pixel (read,
// then check); per object pixel it pops the stack, then pipelines four neighbor reads
// on the single label RAM read port. Reset is asynchronous: geometry returns to
// 256 x 256 and positions clear; RAM is not cleared, every entry read is written first.
module connected_component_labeling_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_enable,
	input  logic                        write_index,
	input  logic [ccl_pkg::CFG_W-1:0]   write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic                        pixel,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ccl_pkg::LABEL_W-1:0] label,
	output logic                        last_label,
	output logic [ccl_pkg::LABEL_W-1:0] region_count
);
	`include "connected_component_labeling_core_assert.svh"

	localparam int XW     = ccl_pkg::XW;
	localparam int YW     = ccl_pkg::YW;
	localparam int ADDR_W = ccl_pkg::ADDR_W;
	localparam int SP_W   = ccl_pkg::SP_W;
	localparam int LW     = ccl_pkg::LABEL_W;

	ccl_pkg::ccl_state_t state_q, state_d;

	logic [ccl_pkg::CFG_W-1:0] width_q, height_q;
	logic [XW-1:0] wm1;
	logic [YW-1:0] hm1;

	logic [XW-1:0] ld_x_q, fx_q, sx_q, qx_q, cur_x;
	logic [YW-1:0] ld_y_q, fy_q, sy_q, qy_q, cur_y;
	logic          done_q;
	logic [SP_W-1:0] sp_q, sp_m1;
	logic [LW-1:0] cnt_q, lbl_q;
	logic [2:0]    k_q;

	logic              nb_rd_s1;
	logic [ADDR_W-1:0] nb_addr_s1;
	logic              pend_s1, last_s1;
	logic [LW-1:0]     cnt_s1;

	logic          out_valid_q, last_q;
	logic [LW-1:0] label_q, count_q;

	// RAM ports
	logic              lm_we;
	logic [ADDR_W-1:0] lm_waddr, lm_raddr;
	logic [LW-1:0]     lm_wdata, lm_rdata;
	logic              sm_we;
	logic [ADDR_W-1:0] sm_waddr, sm_raddr, sm_wdata, sm_rdata;

	logic accept, load_go, fetch_go, load_last, fetch_last, scan_last;
	logic seed, scan_adv, pop, push, nb_ok;
	logic [ADDR_W-1:0] nb_addr;
	logic [XW-1:0] qx_m1, qx_p1;
	logic [YW-1:0] qy_m1, qy_p1;

	ccl_ram #(.WIDTH(LW), .DEPTH(ccl_pkg::PIX_DEPTH)) u_label_ram (
		.clk   (clk),
		.we    (lm_we),
		.waddr (lm_waddr),
		.wdata (lm_wdata),
		.raddr (lm_raddr),
		.rdata (lm_rdata)
	);

	ccl_ram #(.WIDTH(ADDR_W), .DEPTH(ccl_pkg::PIX_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.raddr (sm_raddr),
		.rdata (sm_rdata)
	);

	// Geometry in use: zero counts as one, oversize clamps to the maximum.
	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (32'(width_q) > ccl_pkg::MAX_WIDTH) begin
			wm1 = XW'(ccl_pkg::MAX_WIDTH - 1);
		end else begin
			wm1 = XW'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (32'(height_q) > ccl_pkg::MAX_HEIGHT) begin
			hm1 = YW'(ccl_pkg::MAX_HEIGHT - 1);
		end else begin
			hm1 = YW'(height_q - 1'b1);
		end
	end

	// A load into a complete image restarts it at the first pixel.
	assign cur_x      = done_q ? '0 : ld_x_q;
	assign cur_y      = done_q ? '0 : ld_y_q;
	assign load_last  = (cur_x == wm1) && (cur_y == hm1);
	assign fetch_last = (fx_q == wm1) && (fy_q == hm1);
	assign scan_last  = (sx_q == wm1) && (sy_q == hm1);
	assign sp_m1      = sp_q - 1'b1;

	assign in_stall = (state_q != ccl_pkg::ST_IDLE) ||
		((opcode == ccl_pkg::OP_FETCH) && (pend_s1 || (out_valid_q && out_stall)));
	assign accept   = in_valid && !in_stall;
	assign load_go  = accept && (opcode == ccl_pkg::OP_LOAD);
	assign fetch_go = accept && (opcode == ccl_pkg::OP_FETCH) && done_q;

	assign qx_m1 = qx_q - 1'b1;
	assign qx_p1 = qx_q + 1'b1;
	assign qy_m1 = qy_q - 1'b1;
	assign qy_p1 = qy_q + 1'b1;

	always_comb begin
		case (k_q[1:0])
			2'd0: begin
				nb_ok   = qy_q != '0;
				nb_addr = {qy_m1, qx_q};
			end
			2'd1: begin
				nb_ok   = qy_q != hm1;
				nb_addr = {qy_p1, qx_q};
			end
			2'd2: begin
				nb_ok   = qx_q != '0;
				nb_addr = {qy_q, qx_m1};
			end
			default: begin
				nb_ok   = qx_q != wm1;
				nb_addr = {qy_q, qx_p1};
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		lm_we    = 1'b0;
		lm_waddr = {cur_y, cur_x};
		lm_wdata = {{(LW-1){1'b0}}, pixel};
		lm_raddr = {fy_q, fx_q};
		sm_we    = 1'b0;
		sm_waddr = sp_q[ADDR_W-1:0];
		sm_wdata = nb_addr_s1;
		sm_raddr = sp_m1[ADDR_W-1:0];
		seed     = 1'b0;
		scan_adv = 1'b0;
		pop      = 1'b0;
		push     = 1'b0;
		case (state_q)
			ccl_pkg::ST_IDLE: begin
				if (load_go) begin
					lm_we = 1'b1;
					if (load_last) begin
						state_d = ccl_pkg::ST_SCAN_RD;
					end
				end
			end
			ccl_pkg::ST_SCAN_RD: begin
				lm_raddr = {sy_q, sx_q};
				state_d  = ccl_pkg::ST_SCAN_CHK;
			end
			ccl_pkg::ST_SCAN_CHK: begin
				if (lm_rdata == '0) begin
					// Unlabeled object pixel: open a new region and seed the stack.
					seed     = 1'b1;
					lm_we    = 1'b1;
					lm_waddr = {sy_q, sx_q};
					lm_wdata = cnt_q + LW'(2);
					sm_we    = 1'b1;
					sm_waddr = '0;
					sm_wdata = {sy_q, sx_q};
					state_d  = ccl_pkg::ST_POP;
				end else begin
					scan_adv = 1'b1;
					state_d  = scan_last ? ccl_pkg::ST_IDLE : ccl_pkg::ST_SCAN_RD;
				end
			end
			ccl_pkg::ST_POP: begin
				if (sp_q == '0) begin
					scan_adv = 1'b1;
					state_d  = scan_last ? ccl_pkg::ST_IDLE : ccl_pkg::ST_SCAN_RD;
				end else begin
					pop     = 1'b1;
					state_d = ccl_pkg::ST_POP_WAIT;
				end
			end
			ccl_pkg::ST_POP_WAIT: begin
				state_d = ccl_pkg::ST_NB;
			end
			ccl_pkg::ST_NB: begin
				// Check the neighbor read last cycle while reading the next one.
				if (nb_rd_s1 && (lm_rdata == '0)) begin
					push     = 1'b1;
					lm_we    = 1'b1;
					lm_waddr = nb_addr_s1;
					lm_wdata = lbl_q;
					sm_we    = 1'b1;
				end
				if (!k_q[2]) begin
					lm_raddr = nb_addr;
				end else begin
					state_d = ccl_pkg::ST_POP;
				end
			end
			default: begin
				state_d = ccl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccl_pkg::ST_IDLE;
			width_q     <= ccl_pkg::CFG_RESET;
			height_q    <= ccl_pkg::CFG_RESET;
			ld_x_q      <= '0;
			ld_y_q      <= '0;
			fx_q        <= '0;
			fy_q        <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			done_q      <= 1'b0;
			sp_q        <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			nb_rd_s1    <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			nb_rd_s1 <= (state_q == ccl_pkg::ST_NB) && !k_q[2] && nb_ok;
			pend_s1  <= fetch_go;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (write_enable) begin
				if (write_index == ccl_pkg::REG_WIDTH) begin
					width_q <= write_data;
				end else begin
					height_q <= write_data;
				end
				ld_x_q <= '0;
				ld_y_q <= '0;
				fx_q   <= '0;
				fy_q   <= '0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end

			if (load_go) begin
				done_q <= load_last;
				if (done_q) begin
					fx_q  <= '0;
					fy_q  <= '0;
					cnt_q <= '0;
				end
				if (cur_x == wm1) begin
					ld_x_q <= '0;
					ld_y_q <= cur_y + 1'b1;
				end else begin
					ld_x_q <= cur_x + 1'b1;
					ld_y_q <= cur_y;
				end
				if (load_last) begin
					sx_q <= '0;
					sy_q <= '0;
				end
			end

			if (fetch_go) begin
				if (fetch_last) begin
					fx_q <= '0;
					fy_q <= '0;
				end else if (fx_q == wm1) begin
					fx_q <= '0;
					fy_q <= fy_q + 1'b1;
				end else begin
					fx_q <= fx_q + 1'b1;
				end
			end

			if (scan_adv) begin
				if (sx_q == wm1) begin
					sx_q <= '0;
					sy_q <= sy_q + 1'b1;
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end

			if (seed) begin
				cnt_q <= cnt_q + 1'b1;
				sp_q  <= SP_W'(1);
			end else if (pop) begin
				sp_q <= sp_m1;
			end else if (push) begin
				sp_q <= sp_q + 1'b1;
			end

			if (state_q == ccl_pkg::ST_POP_WAIT) begin
				k_q <= '0;
			end else if (state_q == ccl_pkg::ST_NB) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seed) begin
			lbl_q <= cnt_q + LW'(2);
		end
		if (state_q == ccl_pkg::ST_POP_WAIT) begin
			qx_q <= sm_rdata[XW-1:0];
			qy_q <= sm_rdata[ADDR_W-1:XW];
		end
		nb_addr_s1 <= nb_addr;
		if (fetch_go) begin
			last_s1 <= fetch_last;
			cnt_s1  <= fetch_last ? cnt_q : '0;
		end
		if (pend_s1) begin
			label_q <= lm_rdata;
			last_q  <= last_s1;
			count_q <= cnt_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign label        = label_q;
	assign last_label   = last_q;
	assign region_count = count_q;

	`CCL_ASSERT_IMPL(a_no_result_overwrite, pend_s1, !out_valid_q, "fetch result would overwrite a waiting transaction")
	`CCL_ASSERT_IMPL(a_stack_bound, push, sp_q < SP_W'(ccl_pkg::PIX_DEPTH), "fill stack overflow")
	`CCL_ASSERT_IMPL(a_label_needs_image, state_q != ccl_pkg::ST_IDLE, done_q, "labeling without a complete image")
	`CCL_ASSERT_NEXT(a_pop_reads_stack, pop, state_q == ccl_pkg::ST_POP_WAIT, "stack pop not followed by its read")
endmodule
